@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge, held off during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/csp_pkg.sv @@
package csp_pkg;

  localparam int CHAR_W = 8;
  localparam int LEN_W  = 28;
  localparam int POS_W  = 32;
  localparam int CNT_W  = 12;
  localparam int CODE_W = 4;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [CHAR_W-1:0] CH_0  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_M  = 8'h4D;
  localparam logic [CHAR_W-1:0] CH_I  = 8'h49;
  localparam logic [CHAR_W-1:0] CH_D  = 8'h44;
  localparam logic [CHAR_W-1:0] CH_N  = 8'h4E;
  localparam logic [CHAR_W-1:0] CH_S  = 8'h53;
  localparam logic [CHAR_W-1:0] CH_H  = 8'h48;
  localparam logic [CHAR_W-1:0] CH_P  = 8'h50;
  localparam logic [CHAR_W-1:0] CH_EQ = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_X  = 8'h58;

  typedef enum logic [CODE_W-1:0] {
    OP_M     = 4'd0,
    OP_I     = 4'd1,
    OP_D     = 4'd2,
    OP_N     = 4'd3,
    OP_S     = 4'd4,
    OP_H     = 4'd5,
    OP_P     = 4'd6,
    OP_EQ    = 4'd7,
    OP_X     = 4'd8,
    OP_OTHER = 4'd9,
    OP_TRAIL = 4'd10
  } op_code_t;

  typedef struct packed {
    logic             produce;
    op_code_t         code;
    logic [LEN_W-1:0] length;
    logic [POS_W-1:0] end_pos;
    logic [CNT_W-1:0] count;
    logic             ovf;
    logic             eos;
  } csp_result_t;

  function automatic op_code_t decode_op(input logic [CHAR_W-1:0] ch);
    op_code_t code;
    case (ch)
      CH_M:    code = OP_M;
      CH_I:    code = OP_I;
      CH_D:    code = OP_D;
      CH_N:    code = OP_N;
      CH_S:    code = OP_S;
      CH_H:    code = OP_H;
      CH_P:    code = OP_P;
      CH_EQ:   code = OP_EQ;
      CH_X:    code = OP_X;
      default: code = OP_OTHER;
    endcase
    return code;
  endfunction

  // operations that consume reference bases
  function automatic logic moves_ref(input op_code_t code);
    logic mv;
    case (code)
      OP_M, OP_D, OP_N, OP_EQ, OP_X: mv = 1'b1;
      default:                       mv = 1'b0;
    endcase
    return mv;
  endfunction

endpackage

@@ rtl/csp_state.sv @@
module csp_state
  import csp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [CHAR_W-1:0] character,
  input  logic              first,
  input  logic [POS_W-1:0]  start_position,
  input  logic              last,
  output csp_result_t       res
);

  logic [LEN_W-1:0] acc_r, acc_nxt;
  logic             ovf_r, ovf_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [LEN_W-1:0] acc_base, acc_dig;
  logic             ovf_base, ovf_dig;
  logic [POS_W-1:0] pos_base, pos_op;
  logic [CNT_W-1:0] cnt_base, cnt_op;
  logic [31:0]      acc_sum;
  logic             is_digit;
  op_code_t         code;

  // first word restarts the string
  assign acc_base = first ? '0 : acc_r;
  assign ovf_base = first ? 1'b0 : ovf_r;
  assign cnt_base = first ? '0 : cnt_r;
  assign pos_base = first ? start_position : pos_r;

  assign is_digit = character inside {[CH_0:CH_9]};

  // acc*10 + digit as acc*8 + acc*2 + digit, fits 32 bits
  assign acc_sum = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0}
                 + {28'd0, character[3:0]};
  assign acc_dig = (|acc_sum[31:LEN_W]) ? LEN_MAX : acc_sum[LEN_W-1:0];
  assign ovf_dig = ovf_base | (|acc_sum[31:LEN_W]);

  assign code   = decode_op(character);
  assign pos_op = moves_ref(code) ? pos_base + {{(POS_W-LEN_W){1'b0}}, acc_base} : pos_base;
  assign cnt_op = (cnt_base != CNT_MAX) ? cnt_base + 1'b1 : cnt_base;

  always_comb begin
    res.eos = last;
    if (is_digit) begin
      res.produce = last;
      res.code    = OP_TRAIL;
      res.length  = acc_dig;
      res.ovf     = ovf_dig;
      res.end_pos = pos_base;
      res.count   = cnt_base;
      acc_nxt     = last ? '0 : acc_dig;
      ovf_nxt     = last ? 1'b0 : ovf_dig;
      pos_nxt     = pos_base;
      cnt_nxt     = cnt_base;
    end else begin
      res.produce = 1'b1;
      res.code    = code;
      res.length  = acc_base;
      res.ovf     = ovf_base;
      res.end_pos = pos_op;
      res.count   = cnt_op;
      acc_nxt     = '0;
      ovf_nxt     = 1'b0;
      pos_nxt     = pos_op;
      cnt_nxt     = cnt_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      ovf_r <= 1'b0;
      pos_r <= '0;
      cnt_r <= '0;
    end else if (step_en) begin
      acc_r <= acc_nxt;
      ovf_r <= ovf_nxt;
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ rtl/cigar_string_parser.sv @@
// channel  | direction | words
// ---------+-----------+-----------------------------------------------
// in_      | slave     | one cigar character, first flag, start pos
// out_     | master    | one closed operation or trailing-digit end
//
// one character is taken every cycle unless the output is stalled; a word's result
// sits in the output register the cycle after acceptance
// the rate is set by the run-length update (acc*10+digit with saturation)
// and the position add, both done combinationally against the parse state
// a digit that is not last gives no word out
// reset is synchronous, active low, and clears the parse state and out valid
// a stalled output holds its word; a new character is taken only while the
// output register is empty or being emptied in the same cycle
`include "assert_macros.svh"

module cigar_string_parser
  import csp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // character [7:0], start_position [39:8]
  input  logic        in_tuser,   // first
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // op_code [3:0], op_length [31:4],
                                  // end_position [63:32], op_count [75:64],
                                  // length_overflow [76], zero fill [79:77]
  output logic        out_tlast   // end_of_string
);

  csp_result_t res;
  logic        in_fire;

  logic        out_valid_r, out_valid_nxt;
  op_code_t    code_r;
  logic [LEN_W-1:0] len_r;
  logic [POS_W-1:0] pos_r;
  logic [CNT_W-1:0] cnt_r;
  logic        ovf_r;
  logic        eos_r;

  // skid-free: output register drains in the same cycle it is refilled
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  csp_state u_state (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (in_fire),
    .character      (in_tdata[CHAR_W-1:0]),
    .first          (in_tuser),
    .start_position (in_tdata[CHAR_W+POS_W-1:CHAR_W]),
    .last           (in_tlast),
    .res            (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = res.produce;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_fire && res.produce) begin
      code_r <= res.code;
      len_r  <= res.length;
      pos_r  <= res.end_pos;
      cnt_r  <= res.count;
      ovf_r  <= res.ovf;
      eos_r  <= res.eos;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, ovf_r, cnt_r, pos_r, len_r, code_r};
  assign out_tlast  = eos_r;

  // trailing-digit results only ever come from the last character
  `ASSERT_IMPL(a_trail_is_end, out_tvalid && (code_r == OP_TRAIL), out_tlast,
               "trailing-digit result without end of string")
  // a saturated run shows the maximum length
  `ASSERT_IMPL(a_ovf_len_max, out_tvalid && ovf_r, len_r == LEN_MAX,
               "overflow flag without saturated length")
  // a closed operation always counts at least itself
  `ASSERT_IMPL(a_count_nonzero, out_tvalid && (code_r != OP_TRAIL), cnt_r != '0,
               "operation result with zero count")
  // a mid-string digit never produces a word
  `ASSERT_NEXT(a_digit_silent,
               in_fire && (in_tdata[7:0] >= CH_0) && (in_tdata[7:0] <= CH_9) && !in_tlast,
               !out_tvalid, "digit produced a result")

endmodule

@@ dv/tb_cigar_string_parser.sv @@
module tb_cigar_string_parser;
  import csp_pkg::*;

  // one closed operation as it leaves the parser
  typedef struct packed {
    op_code_t         code;
    logic [LEN_W-1:0] len;
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
    logic             ovf;
    logic             eos;
  } cigar_word_t;

  // one row of the directed sequence; want is only used where typed is set
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              first;
    logic [POS_W-1:0]  sp;
    logic              last;
    logic              typed;
    cigar_word_t       want;
  } dir_row_t;

  localparam int N_DIR = 26;
  localparam int N_RANDOM_CHARS = 1324;
  localparam int MAX_WAIT = 12;
  localparam int N_REPORT = 10;

  localparam logic [CHAR_W-1:0] OP_CHARS [9] =
    '{CH_M, CH_I, CH_D, CH_N, CH_S, CH_H, CH_P, CH_EQ, CH_X};

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // character [7:0], start_position [39:8]
  logic        in_tuser;   // first
  logic        in_tlast;   // last
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;  // op_code [3:0], op_length [31:4], end_position [63:32],
                           // op_count [75:64], length_overflow [76]
  logic        out_tlast;  // end_of_string

  cigar_string_parser i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // parse state of the predictor
  logic [LEN_W-1:0] run_len;
  logic             run_sat;
  logic [POS_W-1:0] ref_end;
  logic [CNT_W-1:0] n_ops;

  cigar_word_t words_due [$];
  dir_row_t    dir_tab [N_DIR];

  bit no_idle;
  int n_chars;
  int n_strings;
  int n_words;
  int n_sat;
  int n_trail;
  int n_bad;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  initial begin
    #(10_000_000);
    $display("FAILURE");
    $finish;
  end

  // switches both sides between random waits and back-to-back stretches
  initial begin
    no_idle = 1'b0;
    forever begin
      repeat ($urandom_range(40, 400)) @(posedge clk);
      no_idle = ($urandom_range(0, 3) == 0);
    end
  end

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // next parse step for one accepted character; returns 1 if a word is due
  function automatic bit parse_char(input logic [CHAR_W-1:0] ch, input logic first,
                                    input logic [POS_W-1:0] sp, input logic last,
                                    output cigar_word_t w);
    logic [35:0] grown;
    logic        adds;
    op_code_t    code;
    w = '0;
    if (first) begin
      run_len = '0;
      run_sat = 1'b0;
      n_ops   = '0;
      ref_end = sp;
    end
    if (ch >= CH_0 && ch <= CH_9) begin
      grown = {8'd0, run_len} * 36'd10 + {28'd0, ch - CH_0};
      if (grown > {8'd0, LEN_MAX}) begin
        run_len = LEN_MAX;
        run_sat = 1'b1;
      end else begin
        run_len = grown[LEN_W-1:0];
      end
      if (!last) return 1'b0;
      code = OP_TRAIL;
    end else begin
      adds = 1'b0;
      case (ch)
        CH_M:  begin code = OP_M;  adds = 1'b1; end
        CH_I:  code = OP_I;
        CH_D:  begin code = OP_D;  adds = 1'b1; end
        CH_N:  begin code = OP_N;  adds = 1'b1; end
        CH_S:  code = OP_S;
        CH_H:  code = OP_H;
        CH_P:  code = OP_P;
        CH_EQ: begin code = OP_EQ; adds = 1'b1; end
        CH_X:  begin code = OP_X;  adds = 1'b1; end
        default: code = OP_OTHER;
      endcase
      if (adds) ref_end = ref_end + {4'd0, run_len};
      if (n_ops != CNT_MAX) n_ops = n_ops + 1'b1;
    end
    w.code = code;
    w.len  = run_len;
    w.pos  = ref_end;
    w.cnt  = n_ops;
    w.ovf  = run_sat;
    w.eos  = last;
    run_len = '0;
    run_sat = 1'b0;
    return 1'b1;
  endfunction

  // offers one character word, waits for it to be taken, books the expected result
  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic first,
                           input logic [POS_W-1:0] sp, input logic last,
                           input logic typed = 1'b0, input cigar_word_t want = '0);
    int          gap;
    cigar_word_t w;
    bit          due;
    gap = draw_wait();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {sp, ch};
    in_tuser  = first;
    in_tlast  = last;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    due = parse_char(ch, first, sp, last, w);
    if (typed) w = want;
    if (due) words_due.push_back(w);
    n_chars++;
    @(negedge clk);
  endtask

  // well-formed cigar text with random content, plus some noise and broken strings
  task automatic send_random_cigar();
    logic [CHAR_W-1:0] text [$];
    logic [POS_W-1:0]  sp;
    int                n_dig;
    int                r;
    bit                fresh;
    bit                unterminated;
    repeat ($urandom_range(1, 8)) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        text.push_back(8'($urandom_range(0, 255)));
      end else begin
        r = $urandom_range(0, 15);
        n_dig = (r == 0) ? 0 : (r == 1) ? $urandom_range(9, 11) : $urandom_range(1, 3);
        repeat (n_dig) text.push_back(CH_0 + 8'($urandom_range(0, 9)));
        text.push_back(OP_CHARS[$urandom_range(0, 8)]);
      end
    end
    // trailing digits close the string with an end-only word
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 3)) text.push_back(CH_0 + 8'($urandom_range(0, 9)));
    fresh        = ($urandom_range(0, 9) != 0);
    unterminated = ($urandom_range(0, 19) == 0);
    case ($urandom_range(0, 7))
      0:       sp = '0;
      1:       sp = '1;
      2:       sp = 32'hFFFF_FFFF - $urandom_range(0, 1000);
      default: sp = $urandom;
    endcase
    foreach (text[i])
      send_char(text[i], fresh && i == 0, (fresh && i == 0) ? sp : $urandom,
                !unterminated && i == text.size() - 1);
    n_strings++;
  endtask

  // result side: random stall before each word
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    cigar_word_t got;
    cigar_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.code = op_code_t'(out_tdata[3:0]);
      got.len  = out_tdata[31:4];
      got.pos  = out_tdata[63:32];
      got.cnt  = out_tdata[75:64];
      got.ovf  = out_tdata[76];
      got.eos  = out_tlast;
      n_words++;
      if (got.ovf) n_sat++;
      if (got.code == OP_TRAIL) n_trail++;
      if (words_due.size() == 0) begin
        n_bad++;
        if (n_bad <= N_REPORT)
          $display("%0t: word with nothing due: code %0d len %0d pos %h cnt %0d ovf %b eos %b",
                   $realtime, got.code, got.len, got.pos, got.cnt, got.ovf, got.eos);
      end else begin
        want = words_due.pop_front();
        if (got !== want) begin
          n_bad++;
          if (n_bad <= N_REPORT) begin
            $display("%0t: mismatch, expected code %0d len %0d pos %h cnt %0d ovf %b eos %b",
                     $realtime, want.code, want.len, want.pos, want.cnt, want.ovf, want.eos);
            $display("%0t:           actual code %0d len %0d pos %h cnt %0d ovf %b eos %b",
                     $realtime, got.code, got.len, got.pos, got.cnt, got.ovf, got.eos);
          end
        end
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    in_tlast  = 1'b0;
    run_len   = '0;
    run_sat   = 1'b0;
    ref_end   = '0;
    n_ops     = '0;
    n_chars   = 0;
    n_strings = 0;
    n_words   = 0;
    n_sat     = 0;
    n_trail   = 0;
    n_bad     = 0;

    // every operation code, a code with no length, unknown and nul characters,
    // length saturation with a start near the top of the range, and trailing digits
    dir_tab = '{
      '{"5",     1'b1, 32'd100,        1'b0, 1'b0, '0},
      '{CH_M,    1'b0, 32'd0,          1'b0, 1'b1,
        '{OP_M, 28'd5, 32'd105, 12'd1, 1'b0, 1'b0}},
      '{CH_I,    1'b0, 32'd0,          1'b0, 1'b1,
        '{OP_I, 28'd0, 32'd105, 12'd2, 1'b0, 1'b0}},
      '{"3",     1'b0, 32'd0,          1'b0, 1'b0, '0},
      '{CH_D,    1'b0, 32'd0,          1'b0, 1'b0, '0},
      '{"2",     1'b0, 32'hFFFF_FFFF,  1'b0, 1'b0, '0},
      '{CH_N,    1'b0, 32'd0,          1'b0, 1'b0, '0},
      '{CH_S,    1'b0, 32'd0,          1'b0, 1'b0, '0},
      '{CH_H,    1'b0, 32'd0,          1'b0, 1'b0, '0},
      '{CH_P,    1'b0, 32'd0,          1'b0, 1'b0, '0},
      '{"4",     1'b0, 32'd0,          1'b0, 1'b0, '0},
      '{CH_EQ,   1'b0, 32'd0,          1'b0, 1'b0, '0},
      '{CH_X,    1'b0, 32'd0,          1'b0, 1'b0, '0},
      '{8'h00,   1'b0, 32'd0,          1'b0, 1'b0, '0},
      '{8'hFF,   1'b0, 32'd0,          1'b1, 1'b0, '0},
      '{"9",     1'b1, 32'hFFFF_FFFF,  1'b0, 1'b0, '0},
      '{"9",     1'b0, 32'd0,          1'b0, 1'b0, '0},
      '{"9",     1'b0, 32'd0,          1'b0, 1'b0, '0},
      '{"9",     1'b0, 32'd0,          1'b0, 1'b0, '0},
      '{"9",     1'b0, 32'd0,          1'b0, 1'b0, '0},
      '{"9",     1'b0, 32'd0,          1'b0, 1'b0, '0},
      '{"9",     1'b0, 32'd0,          1'b0, 1'b0, '0},
      '{"9",     1'b0, 32'd0,          1'b0, 1'b0, '0},
      '{"9",     1'b0, 32'd0,          1'b0, 1'b0, '0},
      '{CH_M,    1'b0, 32'd0,          1'b1, 1'b1,
        '{OP_M, LEN_MAX, 32'h0FFF_FFFE, 12'd1, 1'b1, 1'b1}},
      '{"7",     1'b0, 32'd0,          1'b1, 1'b1,
        '{OP_TRAIL, 28'd7, 32'h0FFF_FFFE, 12'd1, 1'b0, 1'b1}}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i])
      send_char(dir_tab[i].ch, dir_tab[i].first, dir_tab[i].sp, dir_tab[i].last,
                dir_tab[i].typed, dir_tab[i].want);
    n_strings += 3;

    while (n_chars < N_DIR + N_RANDOM_CHARS)
      send_random_cigar();
    in_tvalid = 1'b0;

    while (words_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("parsed %0d characters in %0d strings, %0d words checked",
             n_chars, n_strings, n_words);
    $display("%0d saturated lengths, %0d end-only words, %0d mismatches",
             n_sat, n_trail, n_bad);
    if (n_bad == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
